### sv/bip2c_pkg.sv
`default_nettype none
package bip2c_pkg;

  localparam int MAX_NODES = 256;
  localparam int MAX_EDGES = 4096;
  localparam int NODE_W    = 8;
  localparam int NCNT_W    = 9;   // node count, list start index
  localparam int EIDX_W    = 13;  // edge count, edge index
  localparam int EADR_W    = 12;  // edge store address
  localparam int COL_W     = 2;

  localparam logic [COL_W-1:0] COL_NONE = 2'd0;
  localparam logic [COL_W-1:0] RED      = 2'd1;
  localparam logic [COL_W-1:0] BLUE     = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_ORDER = 2'd3;

  typedef logic [4:0] op_t;
  localparam op_t OP_NOP      = 5'd0;
  localparam op_t OP_TAKE     = 5'd1;
  localparam op_t OP_SETERR   = 5'd2;
  localparam op_t OP_FILL     = 5'd3;
  localparam op_t OP_STORE    = 5'd4;
  localparam op_t OP_RES_BAD  = 5'd5;
  localparam op_t OP_POSTOK   = 5'd6;
  localparam op_t OP_CFILL    = 5'd7;
  localparam op_t OP_CLR      = 5'd8;
  localparam op_t OP_ROOTINIT = 5'd9;
  localparam op_t OP_RES_PASS = 5'd10;
  localparam op_t OP_RDROOT   = 5'd11;
  localparam op_t OP_NEXTROOT = 5'd12;
  localparam op_t OP_START    = 5'd13;
  localparam op_t OP_LSA      = 5'd14;
  localparam op_t OP_LSB      = 5'd15;
  localparam op_t OP_POP      = 5'd16;
  localparam op_t OP_POPLD    = 5'd17;
  localparam op_t OP_EDGE     = 5'd18;
  localparam op_t OP_RDDEST   = 5'd19;
  localparam op_t OP_PUSH     = 5'd20;
  localparam op_t OP_RES_FAIL = 5'd21;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic has_work;
    logic load_err;
    logic need_fill;
    logic last;
    logic bad_final;
    logic cfill_more;
    logic clr_more;
    logic root_done;
    logic root_coloured;
    logic frame_done;
    logic depth_one;
    logic dest_free;
    logic depth_full;
    logic clash;
  } stat_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [EIDX_W-1:0] nxt;
    logic [EIDX_W-1:0] fin;
    logic [COL_W-1:0]  col;
  } frame_t;

endpackage
`default_nettype wire

### sv/bip2c_ctrl.sv
`default_nettype none
module bip2c_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  output bip2c_pkg::cmd_t     cmd,
  input  wire bip2c_pkg::stat_t stat
);
  import bip2c_pkg::*;

  localparam logic [3:0] S_LOAD = 4'd0;
  localparam logic [3:0] S_EDGE = 4'd1;
  localparam logic [3:0] S_POST = 4'd2;
  localparam logic [3:0] S_CFIL = 4'd3;
  localparam logic [3:0] S_CLR  = 4'd4;
  localparam logic [3:0] S_ROOT = 4'd5;
  localparam logic [3:0] S_RTC  = 4'd6;
  localparam logic [3:0] S_LSA  = 4'd7;
  localparam logic [3:0] S_LSB  = 4'd8;
  localparam logic [3:0] S_STEP = 4'd9;
  localparam logic [3:0] S_POPW = 4'd10;
  localparam logic [3:0] S_EW   = 4'd11;
  localparam logic [3:0] S_CC   = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_LOAD;
    else        state_r <= state_nxt;
  end

  assign in_stall  = (state_r != S_LOAD);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NOP;
    unique case (state_r)
      S_LOAD: if (in_valid) begin
        cmd.op = OP_TAKE; state_nxt = S_EDGE;
      end
      S_EDGE: begin
        priority if (!stat.has_work) state_nxt = S_POST;
        else if (stat.load_err) begin
          cmd.op = OP_SETERR; state_nxt = S_POST;
        end else if (stat.need_fill) cmd.op = OP_FILL;
        else begin
          cmd.op = OP_STORE; state_nxt = S_POST;
        end
      end
      S_POST: begin
        priority if (!stat.last) state_nxt = S_LOAD;
        else if (stat.bad_final) begin
          cmd.op = OP_RES_BAD; state_nxt = S_OUT;
        end else begin
          cmd.op = OP_POSTOK; state_nxt = S_CFIL;
        end
      end
      S_CFIL: if (stat.cfill_more) cmd.op = OP_CFILL;
              else state_nxt = S_CLR;
      S_CLR: begin
        if (stat.clr_more) cmd.op = OP_CLR;
        else begin
          cmd.op = OP_ROOTINIT; state_nxt = S_ROOT;
        end
      end
      S_ROOT: begin
        if (stat.root_done) begin
          cmd.op = OP_RES_PASS; state_nxt = S_OUT;
        end else begin
          cmd.op = OP_RDROOT; state_nxt = S_RTC;
        end
      end
      S_RTC: begin
        if (stat.root_coloured) begin
          cmd.op = OP_NEXTROOT; state_nxt = S_ROOT;
        end else begin
          cmd.op = OP_START; state_nxt = S_LSA;
        end
      end
      S_LSA: begin
        cmd.op = OP_LSA; state_nxt = S_LSB;
      end
      S_LSB: begin
        cmd.op = OP_LSB; state_nxt = S_STEP;
      end
      S_STEP: begin
        priority if (!stat.frame_done) begin
          cmd.op = OP_EDGE; state_nxt = S_EW;
        end else if (stat.depth_one) begin
          cmd.op = OP_NEXTROOT; state_nxt = S_ROOT;
        end else begin
          cmd.op = OP_POP; state_nxt = S_POPW;
        end
      end
      S_POPW: begin
        cmd.op = OP_POPLD; state_nxt = S_STEP;
      end
      S_EW: begin
        cmd.op = OP_RDDEST; state_nxt = S_CC;
      end
      S_CC: begin
        priority if (stat.dest_free && !stat.depth_full) begin
          cmd.op = OP_PUSH; state_nxt = S_LSA;
        end else if (stat.dest_free || stat.clash) begin
          cmd.op = OP_RES_FAIL; state_nxt = S_OUT;
        end else state_nxt = S_STEP;
      end
      S_OUT: if (!out_stall) state_nxt = S_LOAD;
      default: state_nxt = S_LOAD;
    endcase
  end

endmodule
`default_nettype wire

### sv/bip2c_dp.sv
`default_nettype none
module bip2c_dp (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [bip2c_pkg::NCNT_W-1:0] cfg_wdata,
  input  wire logic [bip2c_pkg::NODE_W-1:0] in_source_node,
  input  wire logic [bip2c_pkg::NODE_W-1:0] in_neighbour_node,
  input  wire logic                     in_has_edge,
  input  wire logic                     in_last_item,
  output logic                          out_bipartite,
  output logic [1:0]                    out_status,
  input  wire bip2c_pkg::cmd_t          cmd,
  output bip2c_pkg::stat_t              stat
);
  import bip2c_pkg::*;

  // memories
  logic [EIDX_W-1:0] ls_mem [MAX_NODES+1];
  logic [NODE_W-1:0] edge_mem [MAX_EDGES];
  logic [COL_W-1:0]  col_mem [MAX_NODES];
  frame_t            stk_mem [MAX_NODES];

  logic [EIDX_W-1:0] ls_q;
  logic [NODE_W-1:0] edge_q;
  logic [COL_W-1:0]  col_q;
  frame_t            stk_q;

  logic [NCNT_W-1:0] ls_ra;
  logic [NODE_W-1:0] col_ra;
  logic [NODE_W-1:0] stk_ra;

  logic [NCNT_W-1:0] ncount_r;
  logic [NODE_W-1:0] src_r, dst_r, dest_r;
  logic              has_r, last_r;
  logic [EIDX_W-1:0] ecount_r;
  logic [1:0]        err_r;
  logic [NCNT_W-1:0] fill_r, span_r, root_r, depth_r;
  logic [NODE_W-1:0] cur_node_r;
  logic [EIDX_W-1:0] cur_next_r, cur_end_r;
  logic [COL_W-1:0]  cur_col_r;
  logic              res_bip_r;
  logic [1:0]        res_st_r;

  logic [NCNT_W-1:0] n_eff, src9, dst9;
  logic              bad_range, bad_order, bad_full;
  logic [COL_W-1:0]  other_col;
  logic              clear_load;

  assign n_eff = (ncount_r > NCNT_W'(MAX_NODES)) ? NCNT_W'(MAX_NODES) : ncount_r;
  assign src9  = {1'b0, src_r};
  assign dst9  = {1'b0, dst_r};
  assign bad_range = (src9 >= n_eff) || (dst9 >= n_eff);
  assign bad_order = (src9 + 9'd1) < fill_r;
  assign bad_full  = ecount_r >= EIDX_W'(MAX_EDGES);
  assign other_col = (cur_col_r == RED) ? BLUE : RED;
  assign clear_load = (cmd.op == OP_RES_BAD) || (cmd.op == OP_RES_PASS)
                   || (cmd.op == OP_RES_FAIL);

  always_comb begin
    stat.has_work      = has_r && (err_r == ST_OK);
    stat.load_err      = bad_range || bad_order || bad_full;
    stat.need_fill     = fill_r <= src9;
    stat.last          = last_r;
    stat.bad_final     = (err_r != ST_OK) || (span_r > n_eff) || (fill_r > n_eff);
    stat.cfill_more    = fill_r <= n_eff;
    stat.clr_more      = root_r < n_eff;
    stat.root_done     = root_r == n_eff;
    stat.root_coloured = col_q != COL_NONE;
    stat.frame_done    = cur_next_r >= cur_end_r;
    stat.depth_one     = depth_r == 9'd1;
    stat.dest_free     = col_q == COL_NONE;
    stat.depth_full    = depth_r >= NCNT_W'(MAX_NODES);
    stat.clash         = col_q == cur_col_r;
  end

  // read addresses
  always_comb begin
    ls_ra  = {1'b0, cur_node_r} + 9'd1;
    col_ra = edge_q;
    stk_ra = 8'(depth_r - 9'd2);
    unique case (cmd.op)
      OP_START: ls_ra = {1'b0, root_r[NODE_W-1:0]};
      OP_PUSH:  ls_ra = {1'b0, dest_r};
      OP_RDROOT: col_ra = root_r[NODE_W-1:0];
      default: ;
    endcase
  end

  // memory ports
  always_ff @(posedge clk) begin
    ls_q   <= ls_mem[ls_ra];
    edge_q <= edge_mem[cur_next_r[EADR_W-1:0]];
    col_q  <= col_mem[col_ra];
    stk_q  <= stk_mem[stk_ra];
    if (cmd.op == OP_FILL || cmd.op == OP_CFILL) ls_mem[fill_r] <= ecount_r;
    if (cmd.op == OP_STORE) edge_mem[ecount_r[EADR_W-1:0]] <= dst_r;
    if (cmd.op == OP_CLR)   col_mem[root_r[NODE_W-1:0]] <= COL_NONE;
    if (cmd.op == OP_START) col_mem[root_r[NODE_W-1:0]] <= RED;
    if (cmd.op == OP_PUSH) begin
      col_mem[dest_r] <= other_col;
      stk_mem[8'(depth_r - 9'd1)] <= '{node: cur_node_r, nxt: cur_next_r,
                                       fin: cur_end_r, col: cur_col_r};
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ncount_r <= '0;
      ecount_r <= '0;
      err_r    <= ST_OK;
      fill_r   <= '0;
      span_r   <= '0;
    end else begin
      if (cfg_we) ncount_r <= cfg_wdata;
      if (clear_load) begin
        ecount_r <= '0;
        err_r    <= ST_OK;
        fill_r   <= '0;
        span_r   <= '0;
      end else begin
        unique case (cmd.op)
          OP_SETERR: begin
            priority if (bad_range) err_r <= ST_RANGE;
            else if (bad_order)     err_r <= ST_ORDER;
            else                    err_r <= ST_FULL;
          end
          OP_FILL, OP_CFILL: fill_r <= fill_r + 9'd1;
          OP_STORE: begin
            ecount_r <= ecount_r + 13'd1;
            if (src9 + 9'd1 > span_r && src_r >= dst_r) span_r <= src9 + 9'd1;
            else if (dst9 + 9'd1 > span_r)              span_r <= dst9 + 9'd1;
          end
          default: ;
        endcase
      end
    end
  end

  // walk payload
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_TAKE: begin
        src_r  <= in_source_node;
        dst_r  <= in_neighbour_node;
        has_r  <= in_has_edge;
        last_r <= in_last_item;
      end
      OP_POSTOK, OP_ROOTINIT: root_r <= '0;
      OP_CLR, OP_NEXTROOT:    root_r <= root_r + 9'd1;
      OP_START: begin
        cur_node_r <= root_r[NODE_W-1:0];
        cur_col_r  <= RED;
        depth_r    <= 9'd1;
      end
      OP_LSA: cur_next_r <= ls_q;
      OP_LSB: cur_end_r  <= ls_q;
      OP_EDGE: cur_next_r <= cur_next_r + 13'd1;
      OP_RDDEST: dest_r <= edge_q;
      OP_PUSH: begin
        cur_node_r <= dest_r;
        cur_col_r  <= other_col;
        depth_r    <= depth_r + 9'd1;
      end
      OP_POP: depth_r <= depth_r - 9'd1;
      OP_POPLD: begin
        cur_node_r <= stk_q.node;
        cur_next_r <= stk_q.nxt;
        cur_end_r  <= stk_q.fin;
        cur_col_r  <= stk_q.col;
      end
      OP_RES_BAD: begin
        res_bip_r <= 1'b0;
        res_st_r  <= (err_r != ST_OK) ? err_r : ST_RANGE;
      end
      OP_RES_PASS: begin
        res_bip_r <= 1'b1;
        res_st_r  <= ST_OK;
      end
      OP_RES_FAIL: begin
        res_bip_r <= 1'b0;
        res_st_r  <= ST_OK;
      end
      default: ;
    endcase
  end

  assign out_bipartite = res_bip_r;
  assign out_status    = res_st_r;

endmodule
`default_nettype wire

### sv/bipartite_two_colour_check.sv
// Load: each item passes the take, edge and post states, plus a fill step for each list
//   start fixed when a new source node arrives; in_stall is low only in the load state.
// After the last item: the remaining list starts are fixed, colours are cleared, then each
//   uncoloured root starts a depth-first walk that reads each edge and pushes or pops frames.
// Result sits in an output register until taken; the next load starts after that.
// Reset (rst_n low, synchronous): idle, node_count 0, load state cleared; memories keep data.
`default_nettype none
module bipartite_two_colour_check (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [8:0] cfg_node_count,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_source_node,
  input  wire logic [7:0] in_neighbour_node,
  input  wire logic       in_has_edge,
  input  wire logic       in_last_item,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_bipartite,
  output logic [1:0]      out_status
);
  import bip2c_pkg::*;

  cmd_t  cmd;   // controller to datapath
  stat_t stat;  // datapath conditions back

  // sequencer: load, list-start fill, colour clear, depth-first walk, result
  bip2c_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  // edge, list-start, colour and stack memories with their pointers
  bip2c_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_node_count),
    .in_source_node    (in_source_node),
    .in_neighbour_node (in_neighbour_node),
    .in_has_edge       (in_has_edge),
    .in_last_item      (in_last_item),
    .out_bipartite     (out_bipartite),
    .out_status        (out_status),
    .cmd               (cmd),
    .stat              (stat)
  );

endmodule
`default_nettype wire
